FILE: rtl/sha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and helper functions of the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  // byte count of one block and the fill level where the length field starts
  localparam int unsigned BLOCK_BYTES = 64;
  localparam logic [5:0]  LEN_START   = 6'd56;
  localparam logic [5:0]  LAST_SLOT   = 6'd63;
  localparam logic [5:0]  LAST_ROUND  = 6'd63;
  localparam logic [2:0]  LAST_WORD   = 3'd7;
  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam logic [63:0] BYTE_BITS   = 64'd8;

  // source of the byte pushed into the block store
  typedef enum logic [1:0] {
    BSEL_MSG  = 2'd0,
    BSEL_PAD  = 2'd1,
    BSEL_ZERO = 2'd2,
    BSEL_LEN  = 2'd3
  } sha_bsel_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic      push;       // shift one byte into the block store
    sha_bsel_e byte_sel;   // which byte to push
    logic      count_len;  // add eight to the bit length
    logic      load_work;  // copy hash words into the working variables
    logic      round_en;   // run one compression round
    logic [5:0] round_idx; // round number for the constant table
    logic      fold;       // add working variables into the hash words
    logic      reinit;     // restore initial hash and clear the length
    logic [2:0] word_idx;  // digest word shown on the output
  } sha_cmd_t;

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // rotate right by a constant amount
  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    rotr = (v >> n) | (v << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] v);
    big_sigma0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] v);
    big_sigma1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] v);
    small_sigma0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] v);
    small_sigma1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

FILE: rtl/sha_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_if
// Valid/ready channels of the SHA-256 hasher: byte input and digest output.
// ----------------------------------------------------------------------------
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, output msg_byte, output byte_present,
                  output end_of_message, input ready);
  modport sink   (input valid, input msg_byte, input byte_present,
                  input end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        last_word;

  modport source (output valid, output digest_word, output last_word, input ready);
  modport sink   (input valid, input digest_word, input last_word, output ready);
endinterface

FILE: rtl/sha_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_dp
// Datapath: block store used as the rolling schedule window, working
// variables, round logic, hash words and message bit length.
// ----------------------------------------------------------------------------
module sha_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sha_pkg::sha_cmd_t cmd_i,
  input  logic [7:0]        msg_byte_i,
  output logic [31:0]       digest_word_o
);

  // block store, word 0 in the top bits; during compression it holds w[t..t+15]
  logic [511:0]      blk_q, blk_d;
  logic [7:0][31:0]  work_q, work_d;
  logic [7:0][31:0]  hash_q, hash_d;
  logic [63:0]       bitlen_q, bitlen_d;

  // length byte pointer, counts down from the top byte while the length goes out
  logic [2:0] len_byte_q, len_byte_d;

  logic [7:0]  push_byte;
  logic [31:0] w0, w1, w9, w14, w_new;
  logic [31:0] t1, t2, ch, maj;

  // pick the byte to push; length bytes go out most significant first
  always_comb begin
    unique case (cmd_i.byte_sel)
      sha_pkg::BSEL_MSG:  push_byte = msg_byte_i;
      sha_pkg::BSEL_PAD:  push_byte = sha_pkg::PAD_BYTE;
      sha_pkg::BSEL_ZERO: push_byte = 8'h00;
      sha_pkg::BSEL_LEN:  push_byte = bitlen_q[{len_byte_q, 3'b000} +: 8];
      default:            push_byte = 8'h00;
    endcase
  end

  always_comb begin
    len_byte_d = len_byte_q;
    if (cmd_i.push && (cmd_i.byte_sel == sha_pkg::BSEL_LEN)) begin
      len_byte_d = len_byte_q - 3'd1;
    end
    if (cmd_i.reinit) begin
      len_byte_d = 3'd7;
    end
  end

  // schedule taps
  assign w0  = blk_q[511:480];
  assign w1  = blk_q[479:448];
  assign w9  = blk_q[223:192];
  assign w14 = blk_q[63:32];
  assign w_new = sha_pkg::small_sigma1(w14) + w9 + sha_pkg::small_sigma0(w1) + w0;

  // round function
  assign ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
  assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]);
  assign t1  = work_q[7] + sha_pkg::big_sigma1(work_q[4]) + ch
             + sha_pkg::ROUND_K[cmd_i.round_idx] + w0;
  assign t2  = sha_pkg::big_sigma0(work_q[0]) + maj;

  // next-state logic
  always_comb begin
    blk_d    = blk_q;
    work_d   = work_q;
    hash_d   = hash_q;
    bitlen_d = bitlen_q;

    if (cmd_i.push) begin
      blk_d = {blk_q[503:0], push_byte};
    end else if (cmd_i.round_en) begin
      blk_d = {blk_q[479:0], w_new};
    end

    if (cmd_i.count_len) begin
      bitlen_d = bitlen_q + sha_pkg::BYTE_BITS;
    end

    if (cmd_i.load_work) begin
      work_d = hash_q;
    end else if (cmd_i.round_en) begin
      work_d[7] = work_q[6];
      work_d[6] = work_q[5];
      work_d[5] = work_q[4];
      work_d[4] = work_q[3] + t1;
      work_d[3] = work_q[2];
      work_d[2] = work_q[1];
      work_d[1] = work_q[0];
      work_d[0] = t1 + t2;
    end

    if (cmd_i.fold) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = hash_q[i] + work_q[i];
      end
    end

    if (cmd_i.reinit) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = sha_pkg::INIT_HASH[i];
      end
      bitlen_d = '0;
    end
  end

  // control-like state with reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= sha_pkg::INIT_HASH[i];
      end
      bitlen_q   <= '0;
      len_byte_q <= 3'd7;
    end else begin
      hash_q     <= hash_d;
      bitlen_q   <= bitlen_d;
      len_byte_q <= len_byte_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    blk_q  <= blk_d;
    work_q <= work_d;
  end

  assign digest_word_o = hash_q[cmd_i.word_idx];

endmodule

FILE: rtl/sha_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_ctrl
// Controller: takes message words, sequences padding, compression rounds
// and the eight digest words.
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              byte_present_i,
  input  logic              end_of_message_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              last_word_o,
  output sha_pkg::sha_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_COMP = 3'd2;
  localparam logic [2:0] S_FOLD = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_q, state_d;
  logic [5:0] fill_q, fill_d;
  logic [5:0] round_q, round_d;
  logic [2:0] word_q, word_d;
  logic       pad80_q, pad80_d;   // the 0x80 marker is still to go
  logic       len_q, len_d;       // length field is being written
  logic       final_q, final_d;   // the block in flight is the last one
  logic       closing_q, closing_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT);
  assign last_word_o = (word_q == sha_pkg::LAST_WORD);

  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    round_d   = round_q;
    word_d    = word_q;
    pad80_d   = pad80_q;
    len_d     = len_q;
    final_d   = final_q;
    closing_d = closing_q;
    cmd_o          = '0;
    cmd_o.byte_sel = sha_pkg::BSEL_MSG;
    cmd_o.round_idx = round_q;
    cmd_o.word_idx  = word_q;

    unique case (state_q)
      // take message words
      S_IDLE: begin
        if (in_valid_i) begin
          if (byte_present_i) begin
            cmd_o.push      = 1'b1;
            cmd_o.count_len = 1'b1;
            fill_d          = fill_q + 6'd1;
          end
          if (end_of_message_i) begin
            closing_d = 1'b1;
            pad80_d   = 1'b1;
            state_d   = S_PAD;
          end
          if (byte_present_i && (fill_q == sha_pkg::LAST_SLOT)) begin
            cmd_o.load_work = 1'b1;
            round_d         = '0;
            state_d         = S_COMP;
          end
        end
      end
      // one padding or length byte per cycle
      S_PAD: begin
        cmd_o.push = 1'b1;
        fill_d     = fill_q + 6'd1;
        if (pad80_q) begin
          cmd_o.byte_sel = sha_pkg::BSEL_PAD;
          pad80_d        = 1'b0;
        end else if (len_q || (fill_q == sha_pkg::LEN_START)) begin
          cmd_o.byte_sel = sha_pkg::BSEL_LEN;
          len_d          = 1'b1;
          if (fill_q == sha_pkg::LAST_SLOT) begin
            final_d = 1'b1;
          end
        end else begin
          cmd_o.byte_sel = sha_pkg::BSEL_ZERO;
        end
        if (fill_q == sha_pkg::LAST_SLOT) begin
          cmd_o.load_work = 1'b1;
          round_d         = '0;
          state_d         = S_COMP;
        end
      end
      // one round per cycle
      S_COMP: begin
        cmd_o.round_en = 1'b1;
        round_d        = round_q + 6'd1;
        if (round_q == sha_pkg::LAST_ROUND) begin
          state_d = S_FOLD;
        end
      end
      // add into the hash and pick where to go
      S_FOLD: begin
        cmd_o.fold = 1'b1;
        if (final_q) begin
          word_d  = '0;
          state_d = S_EMIT;
        end else if (closing_q) begin
          state_d = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      // eight digest words
      S_EMIT: begin
        if (out_ready_i) begin
          word_d = word_q + 3'd1;
          if (word_q == sha_pkg::LAST_WORD) begin
            cmd_o.reinit = 1'b1;
            closing_d    = 1'b0;
            len_d        = 1'b0;
            final_d      = 1'b0;
            state_d      = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      round_q   <= '0;
      word_q    <= '0;
      pad80_q   <= 1'b0;
      len_q     <= 1'b0;
      final_q   <= 1'b0;
      closing_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      round_q   <= round_d;
      word_q    <= word_d;
      pad80_q   <= pad80_d;
      len_q     <= len_d;
      final_q   <= final_d;
      closing_q <= closing_d;
    end
  end

endmodule

FILE: rtl/sha256_message_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_message_hasher
// SHA-256 over a byte stream, digest out as eight 32-bit words.
// ----------------------------------------------------------------------------
// A byte word is taken while the hasher is idle. The word that completes a
// 64-byte block starts the compression, one round per cycle through a single
// round unit, so input is held off through the 64 rounds and the final hash add.
// A word that ends the message starts padding: one pad or length byte per
// cycle into the block store, plus one or two compressions, before the first
// digest word. The digest then leaves as eight words, word 0 first, one per
// accepted output cycle, and the hash state returns to its initial values for
// the next message.
// ----------------------------------------------------------------------------
module sha256_message_hasher (
  input  logic       clk_i,
  input  logic       rst_ni,
  sha_in_if.sink     in_i,
  sha_out_if.source  out_o
);

  sha_pkg::sha_cmd_t cmd;
  logic              in_ready;
  logic              out_valid;
  logic              last_word;
  logic [31:0]       digest_word;

  // sequencing
  sha_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_i.valid),
    .in_ready_o       (in_ready),
    .byte_present_i   (in_i.byte_present),
    .end_of_message_i (in_i.end_of_message),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_o.ready),
    .last_word_o      (last_word),
    .cmd_o            (cmd)
  );

  // storage and arithmetic
  sha_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .msg_byte_i    (in_i.msg_byte),
    .digest_word_o (digest_word)
  );

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid;
  assign out_o.digest_word = digest_word;
  assign out_o.last_word   = last_word;

endmodule

FILE: tb/tb_sha256_message_hasher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sha256_message_hasher
// Self-checking bench for the SHA-256 byte-stream hasher. A queue of byte
// words feeds a valid/ready driver. An independent SHA-256 model predicts the
// eight digest words of every closed message, and a monitor compares each
// output word in order. Directed corner messages run first, then random
// messages sized around the padding boundaries, under varying backpressure.
// ----------------------------------------------------------------------------
module tb_sha256_message_hasher;

  // input word as offered on the byte channel
  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_word_t;

  // one digest word as seen on the output channel
  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } digest_out_t;

  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV_WORDS [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0]  PAD_MARK    = 8'h80;
  localparam int unsigned CHUNK_BYTES = 64;
  localparam int unsigned LEN_SLOT    = 56;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 150;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // bench-side copies of every block input, known from time zero
  logic       drv_valid   = 1'b0;
  logic [7:0] drv_byte    = 8'h00;
  logic       drv_present = 1'b0;
  logic       drv_end     = 1'b0;
  logic       rcv_ready   = 1'b0;

  sha_in_if  in_if ();
  sha_out_if out_if ();

  assign in_if.valid          = drv_valid;
  assign in_if.msg_byte       = drv_byte;
  assign in_if.byte_present   = drv_present;
  assign in_if.end_of_message = drv_end;
  assign out_if.ready         = rcv_ready;

  sha256_message_hasher i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  in_word_t    pending_words [$];
  digest_out_t expected_digest [$];

  // model state: chaining value, partial chunk, message length in bits
  logic [31:0] chain [8];
  logic [7:0]  chunk_bytes [64];
  int unsigned chunk_fill;
  logic [63:0] msg_bits;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        hold_req      = 1'b0;
  int unsigned hold_left;
  int unsigned words_queued  = 0;
  int unsigned fail_count    = 0;

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
    logic [63:0] dbl;
    dbl = {v, v} >> n;
    return dbl[31:0];
  endfunction

  // one 64-round compression of the full chunk into the chaining value
  function automatic void compress_chunk();
    logic [31:0] sched [64];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] s0, s1, t1, t2;
    int t;
    for (t = 0; t < 16; t++) begin
      sched[t] = {chunk_bytes[4*t], chunk_bytes[4*t+1], chunk_bytes[4*t+2], chunk_bytes[4*t+3]};
    end
    for (t = 16; t < 64; t++) begin
      s0 = ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3);
      s1 = ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10);
      sched[t] = s1 + sched[t-7] + s0 + sched[t-16];
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (t = 0; t < 64; t++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_CONST[t] + sched[t];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endfunction

  function automatic void absorb_byte(input logic [7:0] v);
    chunk_bytes[chunk_fill] = v;
    chunk_fill++;
    if (chunk_fill == CHUNK_BYTES) begin
      compress_chunk();
      chunk_fill = 0;
    end
  endfunction

  // update the model with one accepted word, queue the digest when it closes
  function automatic void advance_hash(input in_word_t w);
    digest_out_t r;
    int i;
    if (w.byte_present) begin
      msg_bits += 64'd8;
      absorb_byte(w.msg_byte);
    end
    if (w.end_of_message) begin
      absorb_byte(PAD_MARK);
      while (chunk_fill != LEN_SLOT) absorb_byte(8'h00);
      for (i = 7; i >= 0; i--) absorb_byte(msg_bits[8*i +: 8]);
      for (i = 0; i < 8; i++) begin
        r.digest_word = chain[i];
        r.last_word   = (i == 7);
        expected_digest = {expected_digest, r};
      end
      chain      = IV_WORDS;
      chunk_fill = 0;
      msg_bits   = '0;
    end
  endfunction

  // byte channel driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_in
    in_word_t nxt;
    if (!rst_ni) begin
      drv_valid   <= 1'b0;
      drv_byte    <= 8'h00;
      drv_present <= 1'b0;
      drv_end     <= 1'b0;
    end else if (!drv_valid || in_if.ready) begin
      if (drv_valid) advance_hash({drv_byte, drv_present, drv_end});
      if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_words.pop_front();
        drv_valid   <= 1'b1;
        drv_byte    <= nxt.msg_byte;
        drv_present <= nxt.byte_present;
        drv_end     <= nxt.end_of_message;
      end else begin
        drv_valid <= 1'b0;
      end
    end
  end

  // long output hold-off counter
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // digest monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin : watch_out
    digest_out_t want;
    if (!rst_ni) begin
      rcv_ready <= 1'b0;
    end else begin
      if (out_if.valid && rcv_ready) begin
        if (expected_digest.size() == 0) begin
          report_mismatch($sformatf("digest word %08h with none expected", out_if.digest_word));
        end else begin
          want = expected_digest.pop_front();
          if (out_if.digest_word !== want.digest_word)
            report_mismatch($sformatf("digest_word %08h, want %08h",
                                      out_if.digest_word, want.digest_word));
          if (out_if.last_word !== want.last_word)
            report_mismatch($sformatf("last_word %b, want %b",
                                      out_if.last_word, want.last_word));
        end
      end
      rcv_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic push_word(input logic [7:0] b, input logic present, input logic close);
    in_word_t w;
    w = {b, present, close};
    pending_words = {pending_words, w};
    if (present || close) words_queued++;
  endtask

  // message of len random bytes, end merged with the last byte or on its own
  task automatic queue_message(input int unsigned len);
    int unsigned k;
    bit merged;
    merged = (len != 0) && ($urandom_range(1) == 1);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(19) == 0) push_word(8'($urandom_range(255)), 1'b0, 1'b0);
      push_word(8'($urandom_range(255)), 1'b1, merged && (k == len - 1));
    end
    if (!merged) push_word(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  // lengths mostly short, many around the one/two padding chunk boundary
  function automatic int unsigned pick_length();
    case ($urandom_range(9))
      0, 1, 2: return $urandom_range(4);
      3, 4, 5: return $urandom_range(72, 52);
      6, 7, 8: return $urandom_range(40, 5);
      default: return $urandom_range(140, 100);
    endcase
  endfunction

  // last message is cut short so the word count lands near the target
  task automatic queue_random(input int unsigned target);
    int unsigned start;
    int unsigned len;
    start = words_queued;
    while (words_queued - start < target) begin
      len = pick_length();
      if (len > target - (words_queued - start)) len = target - (words_queued - start);
      queue_message(len);
    end
  endtask

  // main sequence waits until every queued word is taken and every digest is out
  task automatic drain_all();
    while (pending_words.size() != 0 || drv_valid || expected_digest.size() != 0)
      @(negedge clk_i);
  endtask

  // main sequence
  initial begin
    chain      = IV_WORDS;
    chunk_fill = 0;
    msg_bits   = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed corners, sender and receiver idling
    send_idle_pct = 21;
    recv_idle_pct = 62;
    push_word(8'h00, 1'b0, 1'b1);   // empty message
    push_word(8'hff, 1'b0, 1'b0);   // ignored word
    push_word(8'h61, 1'b1, 1'b0);   // "abc", end with the last byte
    push_word(8'h62, 1'b1, 1'b0);
    push_word(8'h63, 1'b1, 1'b1);
    push_word(8'h00, 1'b1, 1'b1);   // single zero byte
    push_word(8'hff, 1'b1, 1'b0);   // single 0xff, end on its own word
    push_word(8'h00, 1'b0, 1'b1);
    push_word(8'h00, 1'b0, 1'b0);   // ignored word
    push_word(8'h5a, 1'b0, 1'b1);   // empty message again
    push_word(8'hff, 1'b1, 1'b1);
    queue_random(110);
    drain_all();

    // roles swapped, with one long output hold-off while input keeps coming
    send_idle_pct = 62;
    recv_idle_pct = 21;
    hold_req = 1'b1;
    @(negedge clk_i);
    hold_req = 1'b0;
    queue_random(120);
    drain_all();

    // full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(130);
    drain_all();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sha_pkg.sv
rtl/sha_if.sv
rtl/sha_dp.sv
rtl/sha_ctrl.sv
rtl/sha256_message_hasher.sv
tb/tb_sha256_message_hasher.sv
